### sv/percentile_contrast_stretch_top_assert.svh
// Assertion macros shared by the checker of the percentile contrast stretch.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef PERCENTILE_CONTRAST_STRETCH_TOP_ASSERT_SVH
`define PERCENTILE_CONTRAST_STRETCH_TOP_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the active-low reset.
`define PCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/pcs_pkg.sv
// Shared constants, codes and types of the percentile contrast stretch.
// Used by the divider, the top level and the checker.
package pcs_pkg;

	localparam int MAX_PIXELS = 262144;
	localparam int CNT_W      = 19;
	localparam int BIN_W      = 16;
	localparam int PCT_W      = 14;
	localparam int FRAC_W     = 14;
	localparam int DVD_W      = 32;
	localparam int DVS_W      = 16;
	localparam int STEP_W     = 5;

	localparam logic [PCT_W-1:0] FULL_SCALE = 14'd10000;
	localparam logic [PCT_W-1:0] PCT_RESET  = 14'd100;

	// Item kinds carried in tuser.
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;
	localparam logic [1:0] MODE_APPLY  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

### sv/percentile_contrast_stretch_top.sv
// Top level of the percentile contrast stretch: histogram memory, sequencer
// and result register. Depends on pcs_pkg and the serial divider pcs_div.
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  tuser: mode; tdata: pixel
// m_*      out  m_tvalid/m_tready  tdata: value, low_level, high_level, status
// cfg_*    in   cfg_valid/cfg_ready cfg_data: percent_hundredths
//
// A load word reads, increments and writes back one histogram bin.
// An apply word runs one pass of the 32-step shared divider, except when the
// levels are equal or the result is clamped to zero without a division.
// A finish word walks once over all bins, which also clears them, and runs
// four divider passes; an empty histogram skips both and goes to the output.
// After reset a clearing pass over all 65536 bins runs before s_tready rises.
// A result waits in the output register while m_tready is low.
module percentile_contrast_stretch_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] pixel
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] value, [31:16] low_level,
	                               // [47:32] high_level, [49:48] status, rest 0
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data   // [13:0] percent_hundredths
);
	import pcs_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_FIN_MUL, S_FIN_DS, S_FIN_DW,
		S_WALK, S_WALK_END, S_INT_MUL, S_INT_DS, S_INT_DW, S_AP_DS, S_AP_DW, S_OUT
	} state_t;

	state_t state_q;

	// Histogram memory.
	logic [CNT_W-1:0] hist_mem [2**BIN_W];
	logic [CNT_W-1:0] rd_q;
	logic [BIN_W-1:0] mem_addr;
	logic             mem_we;
	logic [CNT_W-1:0] mem_wd;

	logic [PCT_W-1:0]  pct_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [BIN_W-1:0]  low_q;
	logic [BIN_W-1:0]  high_q;
	logic [BIN_W-1:0]  addr_q;
	logic [BIN_W-1:0]  bin_s1;
	logic              walk_v_s1;
	logic [CNT_W-1:0]  cum_q;
	logic [CNT_W-1:0]  rank_q  [4];
	logic [BIN_W-1:0]  val_q   [4];
	logic [3:0]        found_q;
	logic [FRAC_W-1:0] frac_q  [2];
	logic              sel_q;
	logic [DVD_W-1:0]  prod_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [BIN_W-1:0]  res_value_q;
	logic [1:0]        res_status_q;
	logic [1:0]        fin_status_q;
	logic              m_valid_q;
	logic [55:0]       m_data_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [PCT_W-1:0]  p_sat;
	logic [PCT_W-1:0]  p_sel;
	logic [33:0]       rank_prod;
	logic [29:0]       int_prod;
	logic [CNT_W-1:0]  cum_next;
	logic [BIN_W:0]    diff;
	logic [BIN_W:0]    rng;
	logic [BIN_W-1:0]  adiff;
	logic [BIN_W-1:0]  arng;
	logic [DVD_W-1:0]  mag_prod;
	logic              out_free;

	pcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Arithmetic feeding the sequencer.
	always_comb begin
		p_sat     = (pct_q > FULL_SCALE) ? FULL_SCALE : pct_q;
		p_sel     = sel_q ? (FULL_SCALE - p_sat) : p_sat;
		rank_prod = (34'(count_q) + 34'd1) * 34'(p_sel);
		int_prod  = 30'(frac_q[sel_q]) * 30'(val_q[{sel_q, 1'b1}] - val_q[{sel_q, 1'b0}]);
		cum_next  = cum_q + rd_q;
		diff      = {1'b0, s_tdata} - {1'b0, low_q};
		rng       = {1'b0, high_q} - {1'b0, low_q};
		adiff     = diff[BIN_W] ? BIN_W'(-diff) : diff[BIN_W-1:0];
		arng      = rng[BIN_W] ? BIN_W'(-rng) : rng[BIN_W-1:0];
		mag_prod  = {adiff, 16'd0} - {16'd0, adiff};
		out_free  = !m_valid_q || m_tready;
	end

	// Divider request.
	always_comb begin
		div_req.start    = (state_q == S_FIN_DS) || (state_q == S_INT_DS)
			|| (state_q == S_AP_DS);
		div_req.dividend = prod_q;
		div_req.divisor  = (state_q == S_AP_DS) ? dvs_q : DVS_W'(FULL_SCALE);
	end

	// Memory port control.
	always_comb begin
		mem_addr = addr_q;
		mem_we   = 1'b0;
		mem_wd   = '0;
		case (state_q)
			S_CLEAR, S_WALK: begin
				mem_we = 1'b1;
			end
			S_LD_WR: begin
				mem_we = 1'b1;
				mem_wd = rd_q + 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Histogram memory, read-first.
	always_ff @(posedge clk) begin
		rd_q <= hist_mem[mem_addr];
		if (mem_we) begin
			hist_mem[mem_addr] <= mem_wd;
		end
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			pct_q        <= PCT_RESET;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			low_q        <= '0;
			high_q       <= '0;
			addr_q       <= '0;
			walk_v_s1    <= 1'b0;
			sel_q        <= 1'b0;
			found_q      <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			// The result word is raised when issued and dropped once taken.
			if ((state_q == S_OUT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				pct_q <= cfg_data;
			end

			// Cumulative walk over the bins, one behind the read address.
			walk_v_s1 <= (state_q == S_WALK);
			bin_s1    <= addr_q;
			if (walk_v_s1) begin
				cum_q <= cum_next;
				for (int i = 0; i < 4; i++) begin
					if (!found_q[i] && (cum_next > rank_q[i])) begin
						found_q[i] <= 1'b1;
						val_q[i]   <= bin_s1;
					end
				end
			end

			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							MODE_LOAD: begin
								addr_q <= s_tdata;
								if (count_q < CNT_W'(MAX_PIXELS)) begin
									state_q <= S_LD_RD;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							MODE_FINISH: begin
								sel_q <= 1'b0;
								if (count_q == '0) begin
									res_value_q  <= '0;
									res_status_q <= ST_EMPTY;
									ovf_q        <= 1'b0;
									state_q      <= S_OUT;
								end else begin
									fin_status_q <= ovf_q ? ST_OVF : ST_OK;
									state_q      <= S_FIN_MUL;
								end
							end
							MODE_APPLY: begin
								res_status_q <= ST_OK;
								prod_q       <= mag_prod;
								dvs_q        <= arng;
								if (rng == '0) begin
									res_value_q <= (!diff[BIN_W] && (diff != '0)) ? '1 : '0;
									state_q     <= S_OUT;
								end else if ((diff == '0) || (diff[BIN_W] != rng[BIN_W])) begin
									res_value_q <= '0;
									state_q     <= S_OUT;
								end else begin
									state_q <= S_AP_DS;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					count_q <= count_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_FIN_MUL: begin
					prod_q  <= rank_prod[DVD_W-1:0];
					state_q <= S_FIN_DS;
				end
				S_FIN_DS: begin
					state_q <= S_FIN_DW;
				end
				S_FIN_DW: begin
					// Turn the rank into two clamped 0-based positions.
					if (div_rsp.done) begin
						if (div_rsp.quot == '0) begin
							rank_q[{sel_q, 1'b0}] <= '0;
							rank_q[{sel_q, 1'b1}] <= '0;
							frac_q[sel_q]         <= '0;
						end else if (div_rsp.quot >= DVD_W'(count_q)) begin
							rank_q[{sel_q, 1'b0}] <= count_q - 1'b1;
							rank_q[{sel_q, 1'b1}] <= count_q - 1'b1;
							frac_q[sel_q]         <= '0;
						end else begin
							rank_q[{sel_q, 1'b0}] <= div_rsp.quot[CNT_W-1:0] - 1'b1;
							rank_q[{sel_q, 1'b1}] <= div_rsp.quot[CNT_W-1:0];
							frac_q[sel_q]         <= div_rsp.rem[FRAC_W-1:0];
						end
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= S_FIN_MUL;
						end else begin
							sel_q   <= 1'b0;
							addr_q  <= '0;
							cum_q   <= '0;
							found_q <= '0;
							for (int i = 0; i < 4; i++) begin
								val_q[i] <= '1;
							end
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == '1) begin
						state_q <= S_WALK_END;
					end
				end
				S_WALK_END: begin
					state_q <= S_INT_MUL;
				end
				S_INT_MUL: begin
					prod_q  <= DVD_W'(int_prod);
					state_q <= S_INT_DS;
				end
				S_INT_DS: begin
					state_q <= S_INT_DW;
				end
				S_INT_DW: begin
					if (div_rsp.done) begin
						if (!sel_q) begin
							low_q   <= val_q[0] + div_rsp.quot[BIN_W-1:0];
							sel_q   <= 1'b1;
							state_q <= S_INT_MUL;
						end else begin
							high_q       <= val_q[2] + div_rsp.quot[BIN_W-1:0];
							sel_q        <= 1'b0;
							res_value_q  <= '0;
							res_status_q <= fin_status_q;
							count_q      <= '0;
							ovf_q        <= 1'b0;
							state_q      <= S_OUT;
						end
					end
				end
				S_AP_DS: begin
					state_q <= S_AP_DW;
				end
				S_AP_DW: begin
					if (div_rsp.done) begin
						res_value_q <= (div_rsp.quot > DVD_W'(16'hFFFF)) ? '1
							: div_rsp.quot[BIN_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_data_q  <= {6'd0, res_status_q, high_q, low_q, res_value_q};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

endmodule

### sv/pcs_div.sv
// Restoring serial divider, one quotient bit per cycle, 32 steps.
// Depends on pcs_pkg for widths and the request and response structs.
module pcs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pcs_pkg::div_req_t req,
	output pcs_pkg::div_rsp_t rsp
);
	import pcs_pkg::*;

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic              ge;

	// One trial subtraction of the partial remainder.
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Step sequencing and the shifting quotient and remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
				dvd_q  <= {dvd_q[DVD_W-2:0], ge};
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

### sv/pcs_checker.sv
// Port-level checker of the percentile contrast stretch, bound to the top.
// Depends on pcs_pkg and the assertion macros header.
`include "percentile_contrast_stretch_top_assert.svh"

module pcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [13:0] cfg_data
);
	import pcs_pkg::*;

	// A stalled result word holds.
	`PCS_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed under stall")

	// A finish or apply word that is taken leaves the block not ready in the cycle after it.
	`PCS_ASSERT_NXT(a_busy_after, clk, arst_n, s_tvalid && s_tready && (s_tuser == MODE_FINISH || s_tuser == MODE_APPLY), !s_tready, "block ready straight after a finish or apply word")

	// A non-zero stretched value comes only from an apply word, whose status is ok.
	`PCS_ASSERT_IMP(a_apply_ok, clk, arst_n, m_tvalid && (m_tdata[15:0] != 16'd0), m_tdata[49:48] == ST_OK, "non-zero value with a non-ok status")

	// Status code three and the padding bits never appear.
	`PCS_ASSERT_IMP(a_status_legal, clk, arst_n, m_tvalid, (m_tdata[49:48] != 2'd3) && (m_tdata[55:50] == 6'd0), "illegal status or padding in result word")

endmodule

bind percentile_contrast_stretch_top pcs_checker u_pcs_checker (.*);
